>>> hw/rtl/rmq_pkg.sv
// Shared types and constants of the sparse-table range-minimum block.
// No dependencies; used by every module of the block.
`default_nettype none

package rmq_pkg;

	localparam int VALUE_FIELD_W = 32;
	localparam int INDEX_W       = 10;
	localparam int SPAN_W        = INDEX_W + 1;
	localparam int LEVEL_W       = 5;
	localparam int S_TDATA_W     = 56;
	localparam int M_TDATA_W     = 32;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_QUERY,
		OP_ERROR
	} op_kind_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_BUILD,
		BK_GAP
	} back_state_t;

	typedef struct packed {
		op_kind_t                 kind;
		logic                     store;
		logic                     restart;
		logic                     build;
		logic [VALUE_FIELD_W-1:0] value;
		logic [INDEX_W-1:0]       left;
		logic [INDEX_W-1:0]       second;
		logic [LEVEL_W-1:0]       level;
	} op_t;

	typedef struct packed {
		logic [M_TDATA_W-1:0] minimum;
		logic                 range_error;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sparse_table_range_minimum_query.sv
// Top level of the sparse-table range-minimum block: front end, operation
// queue and table engine. Depends on rmq_pkg, rmq_front, rmq_op_queue, rmq_back.
//
//   channel  | dir | tdata                                      | tuser        | tlast
//   s_axis   | in  | value[31:0] left_index[41:32] right[51:42] | cmd          | last_element
//   m_axis   | out | minimum[31:0]                              | range_error  | -
//
// Loads and queries are taken one word per cycle while the four-entry queue has room;
// a query's two table reads are registered as its operation leaves the queue, and its
// minimum then goes into the result buffer. The build after the last load writes
// (count - 2^j + 1) entries per level j and a gap state, through the single write port.
// Reset clears counters and flags; table contents stay unknown, with no clear pass.
// A two-word result buffer and the queue let either side stall independently.
`default_nettype none

module sparse_table_range_minimum_query import rmq_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LOG_LEVELS   = 11,
	parameter int VALUE_WIDTH  = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire  [S_TDATA_W-1:0] s_axis_tdata,  // value, left_index, right_index, zero pad
	input  wire                  s_axis_tuser,  // cmd
	input  wire                  s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // minimum
	output logic                 m_axis_tuser   // range_error
);

	localparam int QUEUE_DEPTH = 4;

	logic                             push_valid;
	logic                             push_ready;
	op_t                              push_op;
	logic                             op_valid;
	logic                             op_pop;
	op_t                              op_head;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
	logic                             building;

	rmq_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.LOG_LEVELS  (LOG_LEVELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.cmd          (s_axis_tuser),
		.value        (s_axis_tdata[VALUE_FIELD_W-1:0]),
		.last_element (s_axis_tlast),
		.left_index   (s_axis_tdata[VALUE_FIELD_W +: INDEX_W]),
		.right_index  (s_axis_tdata[VALUE_FIELD_W + INDEX_W +: INDEX_W]),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_op      (push_op)
	);

	rmq_op_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_op   (push_op),
		.pop_valid (op_valid),
		.pop       (op_pop),
		.pop_op    (op_head),
		.level     (q_level)
	);

	rmq_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.LOG_LEVELS  (LOG_LEVELS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op           (op_head),
		.op_pop       (op_pop),
		.building     (building),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	a_build_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		building |-> !op_pop)
		else $error("operation taken from queue during table build");

	a_error_zero_minimum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("range error word carries a non-zero minimum");

	a_accept_fills_queue: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> q_level != '0)
		else $error("accepted word did not reach the operation queue");

endmodule

`default_nettype wire

>>> hw/rtl/rmq_front.sv
// Front end: accepts words, tracks element count and table state, classifies
// each word into a queue operation. Depends on rmq_pkg.
`default_nettype none

module rmq_front import rmq_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LOG_LEVELS   = 11
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire                      cmd,
	input  wire  [VALUE_FIELD_W-1:0] value,
	input  wire                      last_element,
	input  wire  [INDEX_W-1:0]       left_index,
	input  wire  [INDEX_W-1:0]       right_index,
	output logic                     push_valid,
	input  wire                      push_ready,
	output op_t                      push_op
);

	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

	logic [CW-1:0]      cnt_q;
	logic               ready_q;
	logic [CW-1:0]      cnt_base;
	logic               store;
	logic [SPAN_W-1:0]  span;
	logic [SPAN_W-1:0]  pw;
	logic [LEVEL_W-1:0] lead;
	logic [LEVEL_W-1:0] lvl;
	logic               bad;
	logic               accept;

	assign s_axis_tready = push_ready;
	assign push_valid    = s_axis_tvalid;
	assign accept        = s_axis_tvalid & push_ready;

	always_comb begin
		cnt_base = ready_q ? '0 : cnt_q;
		store    = cnt_base < CW'(MAX_ELEMENTS);
		span     = {1'b0, right_index} - {1'b0, left_index} + SPAN_W'(1);
		lead     = '0;
		for (int b = 0; b < SPAN_W; b++) begin
			if (span[b]) begin
				lead = LEVEL_W'(b);
			end
		end
		lvl = lead;
		if (lead > LEVEL_W'(LOG_LEVELS - 1)) begin
			lvl = LEVEL_W'(LOG_LEVELS - 1);
		end
		pw  = SPAN_W'(1) << lvl;
		bad = !ready_q || (left_index > right_index) ||
			(CMP_W'(right_index) >= CMP_W'(cnt_q));

		push_op.kind    = (cmd == CMD_QUERY) ? (bad ? OP_ERROR : OP_QUERY) : OP_LOAD;
		push_op.store   = store;
		push_op.restart = ready_q;
		push_op.build   = last_element;
		push_op.value   = value;
		push_op.left    = left_index;
		push_op.second  = INDEX_W'({1'b0, right_index} + SPAN_W'(1) - pw);
		push_op.level   = lvl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ready_q <= 1'b0;
		end else if (accept && cmd == CMD_LOAD) begin
			cnt_q   <= cnt_base + CW'(store);
			ready_q <= last_element;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rmq_op_queue.sv
// Short operation queue between the front end and the table engine.
// Depends on rmq_pkg for the operation type.
`default_nettype none

module rmq_op_queue import rmq_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push_valid,
	output logic                        push_ready,
	input  wire op_t                    push_op,
	output logic                        pop_valid,
	input  wire                         pop,
	output op_t                         pop_op,
	output logic [$clog2(DEPTH+1)-1:0]  level
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	op_t           entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = level_q != LW'(DEPTH);
	assign pop_valid  = level_q != '0;
	assign pop_op     = entry_q[rd_ptr_q];
	assign level      = level_q;
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			level_q <= level_q + LW'(do_push) - LW'(do_pop);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rmq_back.sv
// Table engine: holds the level table, runs loads, the level-by-level build
// and two-read queries, and buffers results for the master side. Uses rmq_pkg.
`default_nettype none

module rmq_back import rmq_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LOG_LEVELS   = 11,
	parameter int VALUE_WIDTH  = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  op_valid,
	input  wire op_t             op,
	output logic                 op_pop,
	output logic                 building,
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tuser
);

	localparam int IW    = $clog2(MAX_ELEMENTS);
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int DEPTH = MAX_ELEMENTS * LOG_LEVELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = (VALUE_WIDTH > VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;

	function automatic logic [AW-1:0] tbl_addr(input logic [LEVEL_W-1:0] lvl,
			input logic [IW-1:0] idx);
		return AW'(AW'(lvl) * AW'(MAX_ELEMENTS)) + AW'(idx);
	endfunction

	logic [VALUE_WIDTH-1:0] table_mem [DEPTH];

	back_state_t            state_q, state_d;
	logic [CW-1:0]          cnt_q, cnt_d;
	logic [LEVEL_W-1:0]     lvl_q, lvl_d;
	logic [IW-1:0]          idx_q, idx_d;
	logic [CW-1:0]          base;
	logic [CW-1:0]          half;
	logic                   last_idx;
	logic                   more_levels;
	logic                   credit;
	logic                   out_pop;
	logic [AW-1:0]          rd_a, rd_b, wr_addr;
	logic                   wr_en;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [VALUE_WIDTH-1:0] rd_a_q, rd_b_q, min_v;
	logic [MW-1:0]          in_wide, out_wide;
	logic                   bw_s1, qv_s1, err_s1;
	logic                   bw_d, qv_d, err_d;
	logic [AW-1:0]          wa_s1, wa_d;

	result_t                out_q [2];
	logic                   out_wr_q, out_rd_q;
	logic [1:0]             out_cnt_q;

	assign building      = state_q != BK_RUN;
	assign m_axis_tvalid = out_cnt_q != 2'd0;
	assign m_axis_tdata  = out_q[out_rd_q].minimum;
	assign m_axis_tuser  = out_q[out_rd_q].range_error;
	assign out_pop       = m_axis_tvalid & m_axis_tready;
	assign credit        = ({1'b0, out_cnt_q} + {2'b00, qv_s1}) < 3'd2 || out_pop;

	assign min_v    = ($signed(rd_a_q) < $signed(rd_b_q)) ? rd_a_q : rd_b_q;
	assign in_wide  = MW'(op.value);
	assign out_wide = MW'(min_v);

	assign half        = CW'(1) << (lvl_q - LEVEL_W'(1));
	assign last_idx    = ({1'b0, CW'(idx_q)} + {half, 1'b0}) == {1'b0, cnt_q};
	assign more_levels = (lvl_q < LEVEL_W'(LOG_LEVELS)) && ((cnt_q >> lvl_q) != '0);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		lvl_d   = lvl_q;
		idx_d   = idx_q;
		op_pop  = 1'b0;
		base    = op.restart ? '0 : cnt_q;
		rd_a    = tbl_addr(op.level, IW'(op.left));
		rd_b    = tbl_addr(op.level, IW'(op.second));
		bw_d    = 1'b0;
		qv_d    = 1'b0;
		err_d   = 1'b0;
		wa_d    = tbl_addr(lvl_q, idx_q);
		wr_en   = bw_s1;
		wr_addr = wa_s1;
		wr_data = min_v;
		case (state_q)
			BK_RUN: begin
				if (op_valid) begin
					case (op.kind)
						OP_LOAD: begin
							op_pop = 1'b1;
							cnt_d  = base + CW'(op.store);
							if (op.store) begin
								wr_en   = 1'b1;
								wr_addr = tbl_addr('0, IW'(base));
								wr_data = in_wide[VALUE_WIDTH-1:0];
							end
							if (op.build && (cnt_d >> 1) != '0) begin
								state_d = BK_BUILD;
								lvl_d   = LEVEL_W'(1);
								idx_d   = '0;
							end
						end
						OP_QUERY, OP_ERROR: begin
							if (credit) begin
								op_pop = 1'b1;
								qv_d   = 1'b1;
								err_d  = op.kind == OP_ERROR;
							end
						end
						default: ;
					endcase
				end
			end
			BK_BUILD: begin
				rd_a = tbl_addr(lvl_q - LEVEL_W'(1), idx_q);
				rd_b = tbl_addr(lvl_q - LEVEL_W'(1), idx_q + IW'(half));
				bw_d = 1'b1;
				if (last_idx) begin
					lvl_d   = lvl_q + LEVEL_W'(1);
					idx_d   = '0;
					state_d = BK_GAP;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			BK_GAP: begin
				state_d = more_levels ? BK_BUILD : BK_RUN;
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_a_q <= table_mem[rd_a];
		rd_b_q <= table_mem[rd_b];
	end

	always_ff @(posedge clk) begin
		wa_s1 <= wa_d;
		if (qv_s1) begin
			out_q[out_wr_q].minimum     <= err_s1 ? '0 : out_wide[M_TDATA_W-1:0];
			out_q[out_wr_q].range_error <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_RUN;
			cnt_q     <= '0;
			lvl_q     <= '0;
			idx_q     <= '0;
			bw_s1     <= 1'b0;
			qv_s1     <= 1'b0;
			err_s1    <= 1'b0;
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			lvl_q     <= lvl_d;
			idx_q     <= idx_d;
			bw_s1     <= bw_d;
			qv_s1     <= qv_d;
			err_s1    <= err_d;
			out_wr_q  <= out_wr_q ^ qv_s1;
			out_rd_q  <= out_rd_q ^ out_pop;
			out_cnt_q <= out_cnt_q + 2'(qv_s1) - 2'(out_pop);
		end
	end

endmodule

`default_nettype wire
